@@ hw/rtl/bpsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsd_pkg
// Shared constants, codes and the CRC-32 byte update for the patch decoder.
// ----------------------------------------------------------------------------
package bpsd_pkg;

  // width of the source, target and write cursors
  localparam int OFFSET_WIDTH = 32;

  localparam logic [31:0] MIN_PATCH_LENGTH = 32'd19;
  localparam logic [31:0] FOOTER_BYTES     = 32'd12;
  localparam logic [7:0]  NUM_DATA_MASK    = 8'h7f;
  localparam logic [7:0]  NUM_END_FLAG     = 8'h80;
  localparam logic [31:0] CRC_POLY         = 32'hEDB88320;

  localparam logic [7:0] MAGIC_0 = 8'h42;  // 'B'
  localparam logic [7:0] MAGIC_1 = 8'h50;  // 'P'
  localparam logic [7:0] MAGIC_2 = 8'h53;  // 'S'
  localparam logic [7:0] MAGIC_3 = 8'h31;  // '1'

  // result kinds
  localparam logic [2:0] KIND_SOURCE_READ = 3'd0;
  localparam logic [2:0] KIND_LITERAL     = 3'd1;
  localparam logic [2:0] KIND_SOURCE_COPY = 3'd2;
  localparam logic [2:0] KIND_TARGET_COPY = 3'd3;
  localparam logic [2:0] KIND_HEADER      = 3'd4;
  localparam logic [2:0] KIND_STATUS      = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD_CRC   = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL = 2'd3;

  // command modes
  localparam logic [1:0] MODE_SOURCE_READ = 2'd0;
  localparam logic [1:0] MODE_LITERAL     = 2'd1;
  localparam logic [1:0] MODE_SOURCE_COPY = 2'd2;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [32:0] run_length;
    logic [31:0] copy_address;
    logic [31:0] output_position;
    logic [7:0]  literal_byte;
    logic [31:0] source_size;
    logic [31:0] target_size;
    logic [31:0] source_crc;
    logic [31:0] target_crc;
    logic [1:0]  status;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bpsd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsd_in_if / bpsd_out_if
// Valid/ready channels for patch bytes and decoded result items.
// ----------------------------------------------------------------------------
interface bpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;

  modport source (output valid, output patch_byte, input ready);
  modport sink   (input valid, input patch_byte, output ready);
endinterface

interface bpsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [32:0] run_length;
  logic [31:0] copy_address;
  logic [31:0] output_position;
  logic [7:0]  literal_byte;
  logic [31:0] source_size;
  logic [31:0] target_size;
  logic [31:0] source_crc;
  logic [31:0] target_crc;
  logic [1:0]  status;

  modport source (output valid, output kind, output run_length, output copy_address,
                  output output_position, output literal_byte, output source_size,
                  output target_size, output source_crc, output target_crc,
                  output status, input ready);
  modport sink   (input valid, input kind, input run_length, input copy_address,
                  input output_position, input literal_byte, input source_size,
                  input target_size, input source_crc, input target_crc,
                  input status, output ready);
endinterface

@@ hw/rtl/bps_patch_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_patch_stream_decoder_top
// Streaming decoder for BPS1 delta patches, one patch byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Write patch_length through cfg_write_en / cfg_write_data before the
//   first byte. Patch bytes arrive on patch_in; decoded header, command,
//   literal and final status items leave on result_out.
//   Each byte is decoded in the cycle it is accepted (CRC update, one 64-bit
//   shift-add for numbers, cursor adds) and any result lands in the output
//   register; throughput one byte per cycle while no result is stalled.
//   A byte produces zero or one result item.
//   patch_in.ready is high whenever the output register is empty or being
//   taken, so a stalled receiver stalls the byte stream only while a result
//   waits. After the status item further bytes are taken and dropped.
//   Reset (rst, synchronous) returns to the first magic byte, clears all
//   decoder state and empties the output register; patch_length goes to 0.
// ----------------------------------------------------------------------------
module bps_patch_stream_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [31:0]  cfg_write_data,
  bpsd_in_if.sink      patch_in,
  bpsd_out_if.source   result_out
);

  localparam int OW = bpsd_pkg::OFFSET_WIDTH;

  localparam logic [3:0] PH_MAGIC0   = 4'd0;
  localparam logic [3:0] PH_MAGIC3   = 4'd3;
  localparam logic [3:0] PH_HDR      = 4'd4;
  localparam logic [3:0] PH_META     = 4'd5;
  localparam logic [3:0] PH_BOUNDARY = 4'd6;
  localparam logic [3:0] PH_CMDLEN   = 4'd7;
  localparam logic [3:0] PH_CMDOFF   = 4'd8;
  localparam logic [3:0] PH_LITERAL  = 4'd9;
  localparam logic [3:0] PH_FOOT0    = 4'd10;
  localparam logic [3:0] PH_FOOT1    = 4'd11;
  localparam logic [3:0] PH_FOOT2    = 4'd12;
  localparam logic [3:0] PH_DONE     = 4'd13;

  // state
  logic [31:0]   patch_length;
  logic [3:0]    phase, phase_next;
  logic [31:0]   bytes_seen;
  logic [31:0]   running_crc, crc_next;
  logic [63:0]   number_value, number_value_next;
  logic [3:0]    number_step, number_step_next;
  logic [1:0]    field_index, field_index_next;
  logic [31:0]   held_source_size, held_source_size_next;
  logic [31:0]   metadata_remaining, metadata_remaining_next;
  logic [32:0]   pending_run, pending_run_next;
  logic [1:0]    pending_mode, pending_mode_next;
  logic [OW-1:0] source_cursor, source_cursor_next;
  logic [OW-1:0] target_cursor, target_cursor_next;
  logic [OW-1:0] write_position, write_position_next;
  logic [31:0]   footer_word, footer_word_next;
  logic [31:0]   held_source_crc, held_source_crc_next;
  logic [31:0]   held_target_crc, held_target_crc_next;
  logic [31:0]   crc_snapshot, crc_snapshot_next;

  logic               out_valid;
  bpsd_pkg::result_t  out_data;
  bpsd_pkg::result_t  res;
  logic               res_emit;

  logic        accept;
  logic [7:0]  b;

  // number decoder on the current value (or a fresh one at a command boundary)
  logic        num_fresh;
  logic [63:0] num_in;
  logic [3:0]  step_in;
  logic [63:0] num_sum;
  logic [3:0]  num_step_sum;
  logic        num_done;

  assign b       = patch_in.patch_byte;
  assign accept  = patch_in.valid && patch_in.ready;
  assign num_in  = num_fresh ? 64'd0 : number_value;
  assign step_in = num_fresh ? 4'd0 : number_step;

  bpsd_varint u_varint (
    .value      (num_in),
    .step       (step_in),
    .data       (b),
    .value_next (num_sum),
    .step_next  (num_step_sum),
    .done       (num_done)
  );

  // byte decode
  always_comb begin
    logic [7:0]    magic;
    logic [3:0]    ph;
    logic [32:0]   run;
    logic [63:0]   mag;
    logic [OW-1:0] delta;
    logic [OW-1:0] base;

    phase_next              = phase;
    number_value_next       = number_value;
    number_step_next        = number_step;
    field_index_next        = field_index;
    held_source_size_next   = held_source_size;
    metadata_remaining_next = metadata_remaining;
    pending_run_next        = pending_run;
    pending_mode_next       = pending_mode;
    source_cursor_next      = source_cursor;
    target_cursor_next      = target_cursor;
    write_position_next     = write_position;
    footer_word_next        = footer_word;
    held_source_crc_next    = held_source_crc;
    held_target_crc_next    = held_target_crc;
    crc_snapshot_next       = crc_snapshot;
    crc_next                = bpsd_pkg::crc_byte(running_crc, b);
    res                     = '0;
    res_emit                = 1'b0;
    num_fresh               = 1'b0;
    ph                      = phase;
    run                     = 33'd0;
    mag                     = 64'd0;
    delta                   = '0;
    base                    = '0;

    unique case (phase[1:0])
      2'd0:    magic = bpsd_pkg::MAGIC_0;
      2'd1:    magic = bpsd_pkg::MAGIC_1;
      2'd2:    magic = bpsd_pkg::MAGIC_2;
      default: magic = bpsd_pkg::MAGIC_3;
    endcase

    // a command boundary picks command or footer, then falls through
    if (ph == PH_BOUNDARY) begin
      if ({1'b0, bytes_seen} + {1'b0, bpsd_pkg::FOOTER_BYTES} < {1'b0, patch_length}) begin
        num_fresh = 1'b1;
        ph        = PH_CMDLEN;
      end else begin
        ph = PH_FOOT0;
      end
    end

    if (ph <= PH_MAGIC3) begin
      // magic check
      if (ph == PH_MAGIC0 && patch_length < bpsd_pkg::MIN_PATCH_LENGTH) begin
        phase_next = PH_DONE;
        res_emit   = 1'b1;
        res.kind   = bpsd_pkg::KIND_STATUS;
        res.status = bpsd_pkg::ST_TOO_SMALL;
      end else if (b != magic) begin
        phase_next = PH_DONE;
        res_emit   = 1'b1;
        res.kind   = bpsd_pkg::KIND_STATUS;
        res.status = bpsd_pkg::ST_BAD_MAGIC;
      end else begin
        phase_next = ph + 4'd1;
      end
    end else if (ph == PH_HDR) begin
      // header numbers: source size, target size, metadata length
      number_value_next = num_sum;
      number_step_next  = num_step_sum;
      if (num_done) begin
        number_value_next = 64'd0;
        number_step_next  = 4'd0;
        if (field_index == 2'd0) begin
          held_source_size_next = num_sum[31:0];
          field_index_next      = 2'd1;
        end else if (field_index == 2'd1) begin
          res_emit         = 1'b1;
          res.kind         = bpsd_pkg::KIND_HEADER;
          res.source_size  = held_source_size;
          res.target_size  = num_sum[31:0];
          field_index_next = 2'd2;
        end else begin
          metadata_remaining_next = num_sum[31:0];
          field_index_next        = 2'd0;
          phase_next = (num_sum[31:0] != 32'd0) ? PH_META : PH_BOUNDARY;
        end
      end
    end else if (ph == PH_META) begin
      metadata_remaining_next = metadata_remaining - 32'd1;
      if (metadata_remaining == 32'd1) phase_next = PH_BOUNDARY;
    end else if (ph == PH_CMDLEN) begin
      // command length and mode
      number_value_next = num_sum;
      number_step_next  = num_step_sum;
      phase_next        = PH_CMDLEN;
      if (num_done) begin
        number_value_next = 64'd0;
        number_step_next  = 4'd0;
        if (num_sum[63:34] != 30'd0) begin
          run = {1'b0, 32'hFFFFFFFF} + 33'd1;
        end else begin
          run = {1'b0, num_sum[33:2]} + 33'd1;
        end
        pending_run_next  = run;
        pending_mode_next = num_sum[1:0];
        if (num_sum[1:0] == bpsd_pkg::MODE_SOURCE_READ) begin
          write_position_next = write_position + OW'(run);
          phase_next          = PH_BOUNDARY;
          res_emit            = 1'b1;
          res.kind            = bpsd_pkg::KIND_SOURCE_READ;
          res.run_length      = run;
          res.copy_address    = 32'(write_position);
          res.output_position = 32'(write_position);
        end else if (num_sum[1:0] == bpsd_pkg::MODE_LITERAL) begin
          phase_next = PH_LITERAL;
        end else begin
          phase_next = PH_CMDOFF;
        end
      end
    end else if (ph == PH_CMDOFF) begin
      // relative copy offset
      number_value_next = num_sum;
      number_step_next  = num_step_sum;
      if (num_done) begin
        number_value_next = 64'd0;
        number_step_next  = 4'd0;
        mag   = num_sum >> 1;
        delta = num_sum[0] ? OW'(64'd0 - mag) : OW'(mag);
        if (pending_mode == bpsd_pkg::MODE_SOURCE_COPY) begin
          base               = source_cursor + delta;
          source_cursor_next = base + OW'(pending_run);
        end else begin
          base               = target_cursor + delta;
          target_cursor_next = base + OW'(pending_run);
        end
        write_position_next = write_position + OW'(pending_run);
        phase_next          = PH_BOUNDARY;
        res_emit            = 1'b1;
        res.kind            = {1'b0, pending_mode};
        res.run_length      = pending_run;
        res.copy_address    = 32'(base);
        res.output_position = 32'(write_position);
      end
    end else if (ph == PH_LITERAL) begin
      write_position_next = write_position + OW'(1);
      if (pending_run != 33'd0) pending_run_next = pending_run - 33'd1;
      if (pending_run <= 33'd1) phase_next = PH_BOUNDARY;
      res_emit            = 1'b1;
      res.kind            = bpsd_pkg::KIND_LITERAL;
      res.run_length      = 33'd1;
      res.output_position = 32'(write_position);
      res.literal_byte    = b;
    end else if (ph >= PH_FOOT0 && ph <= PH_FOOT2) begin
      // footer words, little-endian; a fresh footer starts from zero
      base             = '0;
      footer_word_next = ((phase == PH_BOUNDARY) ? 32'd0 : footer_word)
                         | ({24'd0, b} << {field_index, 3'b000});
      if (phase == PH_BOUNDARY) begin
        footer_word_next = {24'd0, b};
        field_index_next = 2'd1;
        phase_next       = PH_FOOT0;
      end else if (field_index != 2'd3) begin
        field_index_next = field_index + 2'd1;
      end else begin
        field_index_next = 2'd0;
        footer_word_next = 32'd0;
        if (ph == PH_FOOT0) begin
          held_source_crc_next = footer_word | ({24'd0, b} << 24);
          phase_next           = PH_FOOT1;
        end else if (ph == PH_FOOT1) begin
          held_target_crc_next = footer_word | ({24'd0, b} << 24);
          crc_snapshot_next    = ~crc_next;
          phase_next           = PH_FOOT2;
        end else begin
          phase_next     = PH_DONE;
          res_emit       = 1'b1;
          res.kind       = bpsd_pkg::KIND_STATUS;
          res.source_crc = held_source_crc;
          res.target_crc = held_target_crc;
          res.status     = ((footer_word | ({24'd0, b} << 24)) == crc_snapshot)
                           ? bpsd_pkg::ST_OK : bpsd_pkg::ST_BAD_CRC;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_length       <= 32'd0;
      phase              <= PH_MAGIC0;
      bytes_seen         <= 32'd0;
      running_crc        <= 32'hFFFFFFFF;
      number_value       <= 64'd0;
      number_step        <= 4'd0;
      field_index        <= 2'd0;
      held_source_size   <= 32'd0;
      metadata_remaining <= 32'd0;
      pending_run        <= 33'd0;
      pending_mode       <= 2'd0;
      source_cursor      <= '0;
      target_cursor      <= '0;
      write_position     <= '0;
      footer_word        <= 32'd0;
      held_source_crc    <= 32'd0;
      held_target_crc    <= 32'd0;
      crc_snapshot       <= 32'd0;
    end else begin
      if (cfg_write_en) patch_length <= cfg_write_data;
      if (accept && phase < PH_DONE) begin
        phase              <= phase_next;
        bytes_seen         <= bytes_seen + 32'd1;
        running_crc        <= crc_next;
        number_value       <= number_value_next;
        number_step        <= number_step_next;
        field_index        <= field_index_next;
        held_source_size   <= held_source_size_next;
        metadata_remaining <= metadata_remaining_next;
        pending_run        <= pending_run_next;
        pending_mode       <= pending_mode_next;
        source_cursor      <= source_cursor_next;
        target_cursor      <= target_cursor_next;
        write_position     <= write_position_next;
        footer_word        <= footer_word_next;
        held_source_crc    <= held_source_crc_next;
        held_target_crc    <= held_target_crc_next;
        crc_snapshot       <= crc_snapshot_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && phase < PH_DONE && res_emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase < PH_DONE && res_emit) out_data <= res;
  end

  assign patch_in.ready             = !rst && (!out_valid || result_out.ready);
  assign result_out.valid           = out_valid;
  assign result_out.kind            = out_data.kind;
  assign result_out.run_length      = out_data.run_length;
  assign result_out.copy_address    = out_data.copy_address;
  assign result_out.output_position = out_data.output_position;
  assign result_out.literal_byte    = out_data.literal_byte;
  assign result_out.source_size     = out_data.source_size;
  assign result_out.target_size     = out_data.target_size;
  assign result_out.source_crc      = out_data.source_crc;
  assign result_out.target_crc      = out_data.target_crc;
  assign result_out.status          = out_data.status;

endmodule

@@ hw/rtl/bpsd_varint.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsd_varint
// One byte of the variable-length number decoder: shift-add into 64 bits.
// ----------------------------------------------------------------------------
module bpsd_varint (
  input  logic [63:0] value,
  input  logic [3:0]  step,
  input  logic [7:0]  data,
  output logic [63:0] value_next,
  output logic [3:0]  step_next,
  output logic        done
);

  logic [63:0] group;
  logic [63:0] addend;
  logic [5:0]  shift;

  assign done  = (data & bpsd_pkg::NUM_END_FLAG) != 8'd0;
  assign shift = 6'(7 * step);

  // data bits plus the weight of the next group, which sits just above them
  always_comb begin
    group = {56'd0, data & bpsd_pkg::NUM_DATA_MASK};
    if (!done) group = group | 64'h80;
    if (step < 4'd9) begin
      addend = group << shift;
    end else if (step == 4'd9) begin
      addend = {data[0], 63'd0};
    end else begin
      addend = 64'd0;
    end
  end

  assign value_next = value + addend;
  assign step_next  = (!done && step < 4'd10) ? step + 4'd1 : step;

endmodule

@@ hw/rtl/bpsd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsd_checker
// Port-level checks on the patch decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bpsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [1:0] out_status
);

  // a waiting result item stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // an empty output register never blocks the byte stream
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // the status item ends the stream
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == bpsd_pkg::KIND_STATUS |=> !out_valid)
    else $error("item after final status");

  // status code only carried by the status item
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != bpsd_pkg::KIND_STATUS |-> out_status == bpsd_pkg::ST_OK)
    else $error("status set on non-status item");

endmodule

bind bps_patch_stream_decoder_top bpsd_checker u_bpsd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (patch_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_kind   (result_out.kind),
  .out_status (result_out.status)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BPS1 patch stream decoder. It builds a
// well-formed patch from random commands, with a directed opening of edge
// values, and predicts every decoded item in a scoreboard class. Both sides
// idle and stall in random bursts; patch_length changes only while idle.
// ----------------------------------------------------------------------------
module tb;
  import bpsd_pkg::*;

  // decoder phases of the predictor
  typedef enum int {
    DEC_MAGIC, DEC_HEADER, DEC_META, DEC_BOUNDARY, DEC_CMD_LEN,
    DEC_CMD_OFF, DEC_LITERAL, DEC_FOOTER, DEC_DONE
  } dec_phase_e;

  localparam logic [1:0] MODE_TARGET_COPY = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: decoder predictor plus queue of expected items
  // --------------------------------------------------------------------------
  class patch_scoreboard;
    result_t     expected_items[$];
    int          fails;
    logic [31:0] patch_len;
    dec_phase_e  phase;
    int          magic_idx, footer_idx, field_idx;
    logic [31:0] seen, crc;
    logic [63:0] num;
    int          num_step;
    logic [31:0] src_size, meta_left;
    logic [32:0] run_len;
    logic [1:0]  mode;
    logic [31:0] src_cur, tgt_cur, wr_pos;
    logic [31:0] foot_word, src_crc, tgt_crc, crc_snap;

    function new();
      fails = 0; patch_len = '0; phase = DEC_MAGIC; magic_idx = 0; footer_idx = 0;
      field_idx = 0; seen = '0; crc = '1; num = '0; num_step = 0; src_size = '0;
      meta_left = '0; run_len = '0; mode = '0; src_cur = '0; tgt_cur = '0;
      wr_pos = '0; foot_word = '0; src_crc = '0; tgt_crc = '0; crc_snap = '0;
    endfunction

    function logic [63:0] weight(int step);
      return (step < 10) ? (64'd1 << (7 * step)) : 64'd0;
    endfunction

    // one group of a variable-length number; 1 when the number is complete
    function bit feed_group(logic [7:0] x);
      num += {57'd0, x[6:0]} * weight(num_step);
      if (x[7]) return 1;
      if (num_step < 10) num_step++;
      num += weight(num_step);
      return 0;
    endfunction

    function void push_item(logic [2:0] kind, logic [32:0] run, logic [31:0] addr,
                            logic [31:0] pos, logic [7:0] lit, logic [1:0] st);
      result_t r;
      r = '0;
      r.kind = kind; r.run_length = run; r.copy_address = addr;
      r.output_position = pos; r.literal_byte = lit; r.status = st;
      if (kind == KIND_HEADER) begin
        r.source_size = src_size;
        r.target_size = num[31:0];
      end
      if (kind == KIND_STATUS) begin
        r.source_crc = src_crc;
        r.target_crc = tgt_crc;
      end
      expected_items.push_back(r);
    endfunction

    // accepted patch byte
    function void note_byte(logic [7:0] b);
      logic [31:0] prev_seen;
      logic [63:0] q, mag, delta;
      logic [31:0] pos, addr;
      logic [7:0]  magic [4];
      magic = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
      if (phase == DEC_DONE) return;
      prev_seen = seen;
      crc = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) crc = crc[0] ? ((crc >> 1) ^ 32'hEDB88320) : (crc >> 1);
      seen++;
      case (phase)
        DEC_MAGIC: begin
          if (magic_idx == 0 && patch_len < MIN_PATCH_LENGTH) begin
            phase = DEC_DONE;
            push_item(KIND_STATUS, 0, 0, 0, 0, ST_TOO_SMALL);
          end else if (b != magic[magic_idx]) begin
            phase = DEC_DONE;
            push_item(KIND_STATUS, 0, 0, 0, 0, ST_BAD_MAGIC);
          end else if (magic_idx == 3) phase = DEC_HEADER;
          else magic_idx++;
          return;
        end
        DEC_HEADER: begin
          if (!feed_group(b)) return;
          if (field_idx == 0) begin
            src_size = num[31:0];
            field_idx = 1;
          end else if (field_idx == 1) begin
            push_item(KIND_HEADER, 0, 0, 0, 0, ST_OK);
            field_idx = 2;
          end else begin
            meta_left = num[31:0];
            field_idx = 0;
            phase = (meta_left != 0) ? DEC_META : DEC_BOUNDARY;
          end
          num = '0; num_step = 0;
          return;
        end
        DEC_META: begin
          meta_left--;
          if (meta_left == 0) phase = DEC_BOUNDARY;
          return;
        end
        default: ;
      endcase
      // command boundary: next byte opens a command or the footer
      if (phase == DEC_BOUNDARY) begin
        if ({32'd0, prev_seen} + 64'd12 < {32'd0, patch_len}) begin
          num = '0; num_step = 0;
          phase = DEC_CMD_LEN;
        end else begin
          foot_word = '0; field_idx = 0; footer_idx = 0;
          phase = DEC_FOOTER;
        end
      end
      case (phase)
        DEC_CMD_LEN: begin
          if (!feed_group(b)) return;
          q = num >> 2;
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          run_len = q[32:0] + 33'd1;
          mode = num[1:0];
          num = '0; num_step = 0;
          if (mode == MODE_SOURCE_READ) begin
            pos = wr_pos;
            wr_pos = wr_pos + run_len[31:0];
            phase = DEC_BOUNDARY;
            push_item(KIND_SOURCE_READ, run_len, pos, pos, 0, ST_OK);
          end else phase = (mode == MODE_LITERAL) ? DEC_LITERAL : DEC_CMD_OFF;
        end
        DEC_CMD_OFF: begin
          if (!feed_group(b)) return;
          mag = num >> 1;
          delta = num[0] ? (64'd0 - mag) : mag;
          num = '0; num_step = 0;
          pos = wr_pos;
          if (mode == MODE_SOURCE_COPY) begin
            src_cur = src_cur + delta[31:0];
            addr = src_cur;
            src_cur = src_cur + run_len[31:0];
          end else begin
            tgt_cur = tgt_cur + delta[31:0];
            addr = tgt_cur;
            tgt_cur = tgt_cur + run_len[31:0];
          end
          wr_pos = wr_pos + run_len[31:0];
          phase = DEC_BOUNDARY;
          push_item({1'b0, mode}, run_len, addr, pos, 0, ST_OK);
        end
        DEC_LITERAL: begin
          pos = wr_pos;
          wr_pos++;
          if (run_len > 0) run_len--;
          if (run_len == 0) phase = DEC_BOUNDARY;
          push_item(KIND_LITERAL, 1, 0, pos, b, ST_OK);
        end
        DEC_FOOTER: begin
          foot_word |= {24'd0, b} << (8 * field_idx);
          if (field_idx < 3) begin
            field_idx++;
            return;
          end
          field_idx = 0;
          if (footer_idx == 0) src_crc = foot_word;
          else if (footer_idx == 1) begin
            tgt_crc = foot_word;
            crc_snap = ~crc;
          end else begin
            phase = DEC_DONE;
            push_item(KIND_STATUS, 0, 0, 0, 0,
                      (foot_word == crc_snap) ? ST_OK : ST_BAD_CRC);
          end
          foot_word = '0;
          footer_idx++;
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a, ref bit bad);
      if (e !== a) begin
        bad = 1;
        if (fails < 10) $display("  %s: expected %0h, got %0h", name, e, a);
      end
    endfunction

    // accepted result item
    function void check_item(result_t got);
      result_t e;
      bit bad;
      bad = 0;
      if (expected_items.size() == 0) begin
        if (fails < 10) $display("unexpected item kind %0d at %0t", got.kind, $realtime);
        fails++;
        return;
      end
      e = expected_items.pop_front();
      if (fails < 10 && e !== got) $display("item mismatch at %0t:", $realtime);
      cmp("kind", e.kind, got.kind, bad);
      cmp("run_length", e.run_length, got.run_length, bad);
      cmp("copy_address", e.copy_address, got.copy_address, bad);
      cmp("output_position", e.output_position, got.output_position, bad);
      cmp("literal_byte", e.literal_byte, got.literal_byte, bad);
      cmp("source_size", e.source_size, got.source_size, bad);
      cmp("target_size", e.target_size, got.target_size, bad);
      cmp("source_crc", e.source_crc, got.source_crc, bad);
      cmp("target_crc", e.target_crc, got.target_crc, bad);
      cmp("status", e.status, got.status, bad);
      if (bad) fails++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write_en = 0;
  logic [31:0] cfg_write_data = '0;
  bpsd_in_if  patch_in();
  bpsd_out_if result_out();

  bps_patch_stream_decoder_top i_dut (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .patch_in(patch_in), .result_out(result_out)
  );

  always #6 clk = ~clk;

  patch_scoreboard sb = new();
  int  bytes_sent = 0;
  bit  quiet = 0;
  int  stall_left = 0;

  initial begin
    patch_in.valid = 0;
    patch_in.patch_byte = '0;
    result_out.ready = 0;
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_out.ready <= 0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      result_out.ready <= 0;
    end else result_out.ready <= 1;
  end

  // result monitor
  always @(posedge clk) begin
    result_t got;
    if (!rst && result_out.valid && result_out.ready) begin
      got.kind = result_out.kind;
      got.run_length = result_out.run_length;
      got.copy_address = result_out.copy_address;
      got.output_position = result_out.output_position;
      got.literal_byte = result_out.literal_byte;
      got.source_size = result_out.source_size;
      got.target_size = result_out.target_size;
      got.source_crc = result_out.source_crc;
      got.target_crc = result_out.target_crc;
      got.status = result_out.status;
      sb.check_item(got);
    end
  end

  // one patch byte, with an optional gap ahead of it
  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      patch_in.valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    patch_in.valid <= 1;
    patch_in.patch_byte <= b;
    do @(posedge clk); while (!(patch_in.valid && patch_in.ready));
    sb.note_byte(b);
    bytes_sent++;
    quiet = (bytes_sent >= 600 && bytes_sent < 800) || bytes_sent >= 1400;
  endtask

  task automatic send_number(logic [63:0] v);
    logic [7:0] x;
    forever begin
      x = {1'b0, v[6:0]};
      v = v >> 7;
      if (v == 0) begin
        send_byte(x | NUM_END_FLAG);
        break;
      end
      send_byte(x);
      v = v - 1;
    end
  endtask

  // stop the sender, drain all results, then write patch_length
  task automatic write_length(logic [31:0] value);
    @(negedge clk);
    patch_in.valid <= 0;
    while (sb.expected_items.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_write_en <= 1;
    cfg_write_data <= value;
    sb.patch_len = value;
    @(negedge clk);
    cfg_write_en <= 0;
  endtask

  task automatic send_command(logic [1:0] m, logic [63:0] len_field, int lits,
                              logic [63:0] off_field);
    send_number({len_field[61:0], m});
    if (m == MODE_LITERAL)
      for (int i = 0; i < lits; i++) send_byte($urandom_range(0, 255));
    else if (m != MODE_SOURCE_READ)
      send_number(off_field);
  endtask

  task automatic random_command();
    logic [1:0]  m;
    logic [63:0] lf, off;
    int n;
    m = $urandom_range(0, 3);
    n = $urandom_range(1, 6);
    if (m == MODE_LITERAL) lf = n - 1;
    else if ($urandom_range(0, 15) == 0) lf = {$urandom, $urandom} >> $urandom_range(2, 40);
    else lf = $urandom_range(0, 200);
    if ($urandom_range(0, 7) == 0) off = {$urandom, $urandom};
    else off = {$urandom_range(0, 400), 1'(($urandom_range(0, 1)))};
    send_command(m, lf, n, off);
  endtask

  initial begin
    logic [31:0] pcrc;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    write_length(32'hFFFF_FFFF);

    // magic and header: longest numbers, then metadata
    send_byte(MAGIC_0); send_byte(MAGIC_1); send_byte(MAGIC_2); send_byte(MAGIC_3);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'h0000_0001_0000_0000);
    send_number(64'd4);
    send_byte(8'h00); send_byte(8'hFF);
    // length register extremes while metadata is skipped
    write_length(32'd0);
    write_length(32'hFFFF_FFFF);
    send_byte(8'hA5); send_byte(8'h5A);

    // directed commands: shortest and saturated runs, a short literal run, offsets
    send_command(MODE_SOURCE_READ, 64'd0, 0, 0);
    send_command(MODE_SOURCE_READ, 64'h3FFF_FFFF_FFFF_FFFF, 0, 0);
    send_command(MODE_LITERAL, 64'd1, 2, 0);
    send_command(MODE_SOURCE_COPY, 64'd3, 0, 64'd11);
    send_command(MODE_SOURCE_COPY, 64'd0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(MODE_TARGET_COPY, 64'd7, 0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_command(MODE_TARGET_COPY, 64'hFFFF_FFFF, 0, 64'd3);

    // random body, with occasional length changes at command boundaries
    while (bytes_sent < 1560) begin
      random_command();
      if ($urandom_range(0, 99) == 0)
        write_length(sb.seen + 32'd13 + $urandom_range(2000, 100000));
    end

    // footer: random source and target CRCs, correct or broken patch CRC
    write_length(sb.seen + FOOTER_BYTES);
    repeat (8) send_byte($urandom_range(0, 255));
    pcrc = sb.crc_snap;
    if ($urandom_range(0, 1) == 0) pcrc[$urandom_range(0, 31)] ^= 1'b1;
    for (int i = 0; i < 4; i++) send_byte(pcrc[8*i +: 8]);
    // bytes after the status item are dropped
    repeat (4) send_byte($urandom_range(0, 255));

    @(negedge clk);
    patch_in.valid <= 0;
    while (sb.expected_items.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (sb.fails == 0 && sb.expected_items.size() == 0)
      $display("bps_patch_stream_decoder_top regression: pass");
    else
      $display("bps_patch_stream_decoder_top regression: fail");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("bps_patch_stream_decoder_top regression: fail");
    $finish;
  end
endmodule
